[design/dop_pkg.sv]
// ---------------------------------------------------------------------------
// dop_pkg: shared definitions for the DHCP options parser
// Register indexes, result status codes, reset values and the result layout.
// ---------------------------------------------------------------------------
package dop_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_COOKIE  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_END     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MSGTYPE = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_REQUEST = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LEASE   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SERVER  = 3'd5;

  // register reset values
  localparam logic [31:0] COOKIE_RST  = 32'h6382_5363;
  localparam logic [7:0]  END_RST     = 8'd255;
  localparam logic [7:0]  MSGTYPE_RST = 8'd53;
  localparam logic [7:0]  REQUEST_RST = 8'd50;
  localparam logic [7:0]  LEASE_RST   = 8'd51;
  localparam logic [7:0]  SERVER_RST  = 8'd54;

  // result status codes
  localparam logic [1:0] STAT_END       = 2'd0;
  localparam logic [1:0] STAT_TRUNC     = 2'd1;
  localparam logic [1:0] STAT_BADCOOKIE = 2'd2;

  // found-flag bit positions
  localparam int unsigned FL_TYPE    = 0;
  localparam int unsigned FL_REQUEST = 1;
  localparam int unsigned FL_LEASE   = 2;
  localparam int unsigned FL_SERVER  = 3;

  // result item, last field (status) in the lowest bits
  typedef struct packed {
    logic [31:0] server_id;
    logic        have_server;
    logic [31:0] lease_time;
    logic        have_lease;
    logic [31:0] requested_addr;
    logic        have_request;
    logic [7:0]  message_type;
    logic        have_type;
    logic [1:0]  status;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);
  localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;

endpackage

[design/dhcp_option_parser.sv]
// ---------------------------------------------------------------------------
// dhcp_option_parser: byte-stream DHCP options parser
// Checks the magic cookie, walks the option TLVs and reports one summary
// item per buffer on the byte marked last.
// ---------------------------------------------------------------------------
// The block takes one byte of the DHCP options area per cycle on the input
// stream (tlast marks the final byte of a buffer) and gives one result item
// for each buffer in the cycle after its last byte is taken. Each byte is a
// combinational update of the parser state, so bytes are taken back to back;
// input stalls only while a finished result sits in the output register and
// the sink is not ready. The user sets option codes and the cookie by the
// write port while no buffer is in progress; the block does not enforce it.
module dhcp_option_parser (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [dop_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [31:0]                        cfg_data,
  // byte input
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // data_byte
  input  logic                               s_tlast,   // last_byte
  // result output
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // status, have_type, message_type, have_request, requested_addr,
  // have_lease, lease_time, have_server, server_id, zero fill
  output logic [dop_pkg::OutDataW-1:0]       m_tdata
);

  typedef enum logic [2:0] {
    PH_COOKIE,
    PH_CODE,
    PH_LEN,
    PH_VALUE,
    PH_DONE
  } phase_t;

  // configuration registers
  logic [31:0] cookie_value;
  logic [7:0]  end_code, msgtype_code, request_code, lease_code, server_code;

  // parser state
  phase_t      phase, phase_next;
  logic [23:0] cookie_shift, cookie_shift_next;
  logic [2:0]  cookie_count, cookie_count_next;
  logic [7:0]  current_code, current_code_next;
  logic [7:0]  remaining_len, remaining_len_next;
  logic [31:0] pending_value, pending_value_next;
  logic [2:0]  value_index, value_index_next;
  logic [7:0]  saved_type, saved_type_next;
  logic [31:0] saved_request, saved_request_next;
  logic [31:0] saved_lease, saved_lease_next;
  logic [31:0] saved_server, saved_server_next;
  logic [3:0]  found_flags, found_flags_next;
  logic [1:0]  end_status, end_status_next;

  logic            accept;
  logic            do_commit;
  logic [7:0]      len_dec;
  logic [31:0]     cookie_full;
  logic            ok;
  dop_pkg::result_t result;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cookie_value <= dop_pkg::COOKIE_RST;
      end_code     <= dop_pkg::END_RST;
      msgtype_code <= dop_pkg::MSGTYPE_RST;
      request_code <= dop_pkg::REQUEST_RST;
      lease_code   <= dop_pkg::LEASE_RST;
      server_code  <= dop_pkg::SERVER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dop_pkg::REG_COOKIE:  cookie_value <= cfg_data;
        dop_pkg::REG_END:     end_code     <= cfg_data[7:0];
        dop_pkg::REG_MSGTYPE: msgtype_code <= cfg_data[7:0];
        dop_pkg::REG_REQUEST: request_code <= cfg_data[7:0];
        dop_pkg::REG_LEASE:   lease_code   <= cfg_data[7:0];
        dop_pkg::REG_SERVER:  server_code  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // per-byte parser step
  always_comb begin
    phase_next         = phase;
    cookie_shift_next  = cookie_shift;
    cookie_count_next  = cookie_count;
    current_code_next  = current_code;
    remaining_len_next = remaining_len;
    pending_value_next = pending_value;
    value_index_next   = value_index;
    end_status_next    = end_status;
    do_commit          = 1'b0;
    cookie_full        = {cookie_shift, s_tdata};
    len_dec            = remaining_len - 8'd1;

    unique case (phase)
      PH_COOKIE: begin
        cookie_shift_next = cookie_full[23:0];
        cookie_count_next = cookie_count + 3'd1;
        if (cookie_count == 3'd3) begin
          if (cookie_full != cookie_value) begin
            end_status_next = dop_pkg::STAT_BADCOOKIE;
            phase_next      = PH_DONE;
          end else begin
            phase_next = PH_CODE;
          end
        end
      end
      PH_CODE: begin
        if (s_tdata == end_code) begin
          end_status_next = dop_pkg::STAT_END;
          phase_next      = PH_DONE;
        end else begin
          current_code_next = s_tdata;
          phase_next        = PH_LEN;
        end
      end
      PH_LEN: begin
        remaining_len_next = s_tdata;
        pending_value_next = '0;
        value_index_next   = '0;
        if (s_tdata == 8'd0) begin
          do_commit  = 1'b1;
          phase_next = PH_CODE;
        end else begin
          phase_next = PH_VALUE;
        end
      end
      PH_VALUE: begin
        // keep the first four value bytes, first byte most significant
        if (!value_index[2]) begin
          unique case (value_index[1:0])
            2'd0: pending_value_next[31:24] = s_tdata;
            2'd1: pending_value_next[23:16] = s_tdata;
            2'd2: pending_value_next[15:8]  = s_tdata;
            2'd3: pending_value_next[7:0]   = s_tdata;
            default: ;
          endcase
          value_index_next = value_index + 3'd1;
        end
        remaining_len_next = len_dec;
        if (len_dec == 8'd0) begin
          do_commit  = 1'b1;
          phase_next = PH_CODE;
        end
      end
      PH_DONE: ;
      default: ;
    endcase
  end

  // store a finished option; first matching code wins
  always_comb begin
    saved_type_next    = saved_type;
    saved_request_next = saved_request;
    saved_lease_next   = saved_lease;
    saved_server_next  = saved_server;
    found_flags_next   = found_flags;
    if (do_commit) begin
      priority if (current_code == msgtype_code) begin
        saved_type_next = pending_value_next[31:24];
        found_flags_next[dop_pkg::FL_TYPE] = 1'b1;
      end else if (current_code == request_code) begin
        saved_request_next = pending_value_next;
        found_flags_next[dop_pkg::FL_REQUEST] = 1'b1;
      end else if (current_code == lease_code) begin
        saved_lease_next = pending_value_next;
        found_flags_next[dop_pkg::FL_LEASE] = 1'b1;
      end else if (current_code == server_code) begin
        saved_server_next = pending_value_next;
        found_flags_next[dop_pkg::FL_SERVER] = 1'b1;
      end
    end
  end

  // summary of the buffer as it stands after this byte
  always_comb begin
    unique case (phase_next)
      PH_DONE:   result.status = end_status_next;
      PH_COOKIE: result.status = dop_pkg::STAT_BADCOOKIE;
      default:   result.status = dop_pkg::STAT_TRUNC;
    endcase
    ok = (result.status != dop_pkg::STAT_BADCOOKIE);
    result.have_type      = ok && found_flags_next[dop_pkg::FL_TYPE];
    result.message_type   = result.have_type ? saved_type_next : '0;
    result.have_request   = ok && found_flags_next[dop_pkg::FL_REQUEST];
    result.requested_addr = result.have_request ? saved_request_next : '0;
    result.have_lease     = ok && found_flags_next[dop_pkg::FL_LEASE];
    result.lease_time     = result.have_lease ? saved_lease_next : '0;
    result.have_server    = ok && found_flags_next[dop_pkg::FL_SERVER];
    result.server_id      = result.have_server ? saved_server_next : '0;
  end

  // parser state; cleared after each last byte
  always_ff @(posedge clk) begin
    if (rst || (accept && s_tlast)) begin
      phase         <= PH_COOKIE;
      cookie_shift  <= '0;
      cookie_count  <= '0;
      current_code  <= '0;
      remaining_len <= '0;
      pending_value <= '0;
      value_index   <= '0;
      saved_type    <= '0;
      saved_request <= '0;
      saved_lease   <= '0;
      saved_server  <= '0;
      found_flags   <= '0;
      end_status    <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      cookie_shift  <= cookie_shift_next;
      cookie_count  <= cookie_count_next;
      current_code  <= current_code_next;
      remaining_len <= remaining_len_next;
      pending_value <= pending_value_next;
      value_index   <= value_index_next;
      saved_type    <= saved_type_next;
      saved_request <= saved_request_next;
      saved_lease   <= saved_lease_next;
      saved_server  <= saved_server_next;
      found_flags   <= found_flags_next;
      end_status    <= end_status_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tlast) begin
      m_tdata <= dop_pkg::OutDataW'(result);
    end
  end

endmodule

[tb/tb_dhcp_option_parser.sv]
// ---------------------------------------------------------------------------
// tb_dhcp_option_parser: self-checking bench for the DHCP options parser
// Feeds option buffers one byte per item with random stalls on both sides,
// predicts each summary item in the bench or reads it from the directed table, and compares it field by field.
// ---------------------------------------------------------------------------
module tb_dhcp_option_parser;

  // parser phases of the bench's own copy of the packet state
  typedef enum logic [2:0] {
    P_COOKIE,
    P_CODE,
    P_LEN,
    P_VALUE,
    P_DONE
  } parse_phase_t;

  // one row of the directed table
  typedef struct {
    logic [7:0]       data;
    logic             last;
    bit               fixed;
    dop_pkg::result_t want;
  } stim_row_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [dop_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [31:0]                  cfg_data = '0;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [7:0]                   s_tdata = '0;   // data_byte
  logic                         s_tlast = 1'b0; // last_byte
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  // status, have_type, message_type, have_request, requested_addr,
  // have_lease, lease_time, have_server, server_id, zero fill
  logic [dop_pkg::OutDataW-1:0] m_tdata;

  dhcp_option_parser dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  // register copies
  logic [31:0] cfg_cookie;
  logic [7:0]  cfg_end, cfg_msgtype, cfg_request, cfg_lease, cfg_server;

  // packet state copies
  parse_phase_t ph;
  logic [31:0]  cookie_acc;
  logic [2:0]   cookie_cnt;
  logic [7:0]   cur_code;
  logic [7:0]   len_left;
  logic [31:0]  value_acc;
  logic [2:0]   value_idx;
  logic [7:0]   sv_type;
  logic [31:0]  sv_request, sv_lease, sv_server;
  logic [3:0]   found;
  logic [1:0]   done_status;

  dop_pkg::result_t expected_summaries[$];
  stim_row_t        directed_rows[$];
  logic [7:0]       pkt_bytes[$];
  int               mismatch_count = 0;
  int               items_sent = 0;
  bit               calm = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  task automatic clear_packet();
    ph = P_COOKIE;
    cookie_acc = '0;
    cookie_cnt = '0;
    cur_code = '0;
    len_left = '0;
    value_acc = '0;
    value_idx = '0;
    sv_type = '0;
    sv_request = '0;
    sv_lease = '0;
    sv_server = '0;
    found = '0;
    done_status = dop_pkg::STAT_END;
  endtask

  // keep a finished option; the first matching code wins
  task automatic store_option();
    if (cur_code == cfg_msgtype) begin
      sv_type = value_acc[31:24];
      found[dop_pkg::FL_TYPE] = 1'b1;
    end else if (cur_code == cfg_request) begin
      sv_request = value_acc;
      found[dop_pkg::FL_REQUEST] = 1'b1;
    end else if (cur_code == cfg_lease) begin
      sv_lease = value_acc;
      found[dop_pkg::FL_LEASE] = 1'b1;
    end else if (cur_code == cfg_server) begin
      sv_server = value_acc;
      found[dop_pkg::FL_SERVER] = 1'b1;
    end
  endtask

  // advance the packet state by one byte; a last byte yields a summary
  task automatic parse_byte(input logic [7:0] b, input logic last,
                            output bit has_summary, output dop_pkg::result_t summary);
    bit ok;
    has_summary = 1'b0;
    summary = '0;
    case (ph)
      P_COOKIE: begin
        cookie_acc = {cookie_acc[23:0], b};
        cookie_cnt = cookie_cnt + 3'd1;
        if (cookie_cnt >= 3'd4) begin
          if (cookie_acc != cfg_cookie) begin
            done_status = dop_pkg::STAT_BADCOOKIE;
            ph = P_DONE;
          end else begin
            ph = P_CODE;
          end
        end
      end
      P_CODE: begin
        if (b == cfg_end) begin
          done_status = dop_pkg::STAT_END;
          ph = P_DONE;
        end else begin
          cur_code = b;
          ph = P_LEN;
        end
      end
      P_LEN: begin
        len_left = b;
        value_acc = '0;
        value_idx = '0;
        if (b == 8'd0) begin
          store_option();
          ph = P_CODE;
        end else begin
          ph = P_VALUE;
        end
      end
      P_VALUE: begin
        // only the first four value bytes count, first one on top
        if (value_idx < 3'd4) begin
          value_acc = value_acc | ({24'd0, b} << (24 - 8 * int'(value_idx)));
          value_idx = value_idx + 3'd1;
        end
        len_left = len_left - 8'd1;
        if (len_left == 8'd0) begin
          store_option();
          ph = P_CODE;
        end
      end
      default: ;
    endcase

    if (last) begin
      if (ph == P_DONE) summary.status = done_status;
      else if (ph == P_COOKIE) summary.status = dop_pkg::STAT_BADCOOKIE;
      else summary.status = dop_pkg::STAT_TRUNC;
      ok = (summary.status != dop_pkg::STAT_BADCOOKIE);
      summary.have_type = ok && found[dop_pkg::FL_TYPE];
      summary.message_type = summary.have_type ? sv_type : 8'd0;
      summary.have_request = ok && found[dop_pkg::FL_REQUEST];
      summary.requested_addr = summary.have_request ? sv_request : 32'd0;
      summary.have_lease = ok && found[dop_pkg::FL_LEASE];
      summary.lease_time = summary.have_lease ? sv_lease : 32'd0;
      summary.have_server = ok && found[dop_pkg::FL_SERVER];
      summary.server_id = summary.have_server ? sv_server : 32'd0;
      has_summary = 1'b1;
      clear_packet();
    end
  endtask

  // offer one byte, wait for it to be taken, then predict
  task automatic send_byte(input logic [7:0] b, input logic last,
                           input bit fixed, input dop_pkg::result_t want);
    bit               has_summary;
    dop_pkg::result_t summary;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 37) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    parse_byte(b, last, has_summary, summary);
    if (has_summary) expected_summaries.push_back(fixed ? want : summary);
  endtask

  // stop offering and wait until every summary has come back
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_summaries.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dop_pkg::CfgIdxW-1:0] idx,
                           input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dop_pkg::REG_COOKIE:  cfg_cookie = val;
      dop_pkg::REG_END:     cfg_end = val[7:0];
      dop_pkg::REG_MSGTYPE: cfg_msgtype = val[7:0];
      dop_pkg::REG_REQUEST: cfg_request = val[7:0];
      dop_pkg::REG_LEASE:   cfg_lease = val[7:0];
      dop_pkg::REG_SERVER:  cfg_server = val[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [31:0] cookie, input logic [7:0] end_c,
                                input logic [7:0] msg_c, input logic [7:0] req_c,
                                input logic [7:0] lease_c, input logic [7:0] srv_c);
    write_reg(dop_pkg::REG_COOKIE, cookie);
    write_reg(dop_pkg::REG_END, {24'd0, end_c});
    write_reg(dop_pkg::REG_MSGTYPE, {24'd0, msg_c});
    write_reg(dop_pkg::REG_REQUEST, {24'd0, req_c});
    write_reg(dop_pkg::REG_LEASE, {24'd0, lease_c});
    write_reg(dop_pkg::REG_SERVER, {24'd0, srv_c});
  endtask

  task automatic add_row(input logic [7:0] data, input logic last);
    stim_row_t row;
    row.data = data;
    row.last = last;
    row.fixed = 1'b0;
    row.want = '0;
    directed_rows.push_back(row);
  endtask

  // closing byte of a buffer whose summary is typed in
  task automatic add_checked_row(input logic [7:0] data, input dop_pkg::result_t want);
    stim_row_t row;
    row.data = data;
    row.last = 1'b1;
    row.fixed = 1'b1;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  task automatic push_cookie(input logic [31:0] w, input int nbytes);
    for (int i = 0; i < nbytes; i++) pkt_bytes.push_back(w[31 - 8 * i -: 8]);
  endtask

  // random buffer: mostly well-formed option lists, some noise and broken ones
  task automatic build_packet();
    int         kind, r, len, cut;
    logic [7:0] code;
    pkt_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 8)) pkt_bytes.push_back(8'($urandom));
    end else if (kind < 14) begin
      // cookie with one bit wrong, then bytes to be ignored
      push_cookie(cfg_cookie ^ (32'd1 << $urandom_range(31)), 4);
      repeat ($urandom_range(0, 4)) pkt_bytes.push_back(8'($urandom));
    end else if (kind < 18) begin
      push_cookie(cfg_cookie, $urandom_range(1, 3));
    end else begin
      push_cookie(cfg_cookie, 4);
      repeat ($urandom_range(0, 4)) begin
        r = $urandom_range(99);
        if (r < 60) begin
          case ($urandom_range(3))
            0: code = cfg_msgtype;
            1: code = cfg_request;
            2: code = cfg_lease;
            default: code = cfg_server;
          endcase
        end else if (r < 70) begin
          code = 8'd0;
        end else begin
          code = 8'($urandom);
        end
        r = $urandom_range(99);
        if (r < 70) len = $urandom_range(0, 5);
        else if (r < 99) len = $urandom_range(6, 12);
        else len = $urandom_range(13, 255);
        pkt_bytes.push_back(code);
        pkt_bytes.push_back(8'(len));
        repeat (len) pkt_bytes.push_back(8'($urandom));
      end
      if ($urandom_range(99) < 60) begin
        pkt_bytes.push_back(cfg_end);
        repeat ($urandom_range(0, 3)) pkt_bytes.push_back(8'($urandom));
      end
      // cut the buffer short somewhere after the cookie
      if ($urandom_range(99) < 25 && pkt_bytes.size() > 5) begin
        cut = $urandom_range(5, pkt_bytes.size());
        while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin : check_summaries
    dop_pkg::result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = dop_pkg::result_t'(m_tdata[dop_pkg::ResultW-1:0]);
      if (expected_summaries.size() == 0) begin
        report_mismatch("result with nothing expected", 32'(got.status), 32'd0);
      end else begin
        want = expected_summaries.pop_front();
        check_field("status", 32'(got.status), 32'(want.status));
        check_field("have_type", 32'(got.have_type), 32'(want.have_type));
        check_field("message_type", 32'(got.message_type), 32'(want.message_type));
        check_field("have_request", 32'(got.have_request), 32'(want.have_request));
        check_field("requested_addr", got.requested_addr, want.requested_addr);
        check_field("have_lease", 32'(got.have_lease), 32'(want.have_lease));
        check_field("lease_time", got.lease_time, want.lease_time);
        check_field("have_server", 32'(got.have_server), 32'(want.have_server));
        check_field("server_id", got.server_id, want.server_id);
      end
    end
  end

  // result sink with random stalls
  always @(negedge clk) m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 37);

  // main sequence
  initial begin : stimulus
    dop_pkg::result_t bad_cookie;
    dop_pkg::result_t none;
    int               target;
    bad_cookie = '0;
    bad_cookie.status = dop_pkg::STAT_BADCOOKIE;
    none = '0;
    cfg_cookie = dop_pkg::COOKIE_RST;
    cfg_end = dop_pkg::END_RST;
    cfg_msgtype = dop_pkg::MSGTYPE_RST;
    cfg_request = dop_pkg::REQUEST_RST;
    cfg_lease = dop_pkg::LEASE_RST;
    cfg_server = dop_pkg::SERVER_RST;
    clear_packet();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: cookie cut after one byte
    add_checked_row(8'hFF, bad_cookie);
    // wrong cookie, trailing byte ignored
    add_row(8'h63, 1'b0);
    add_row(8'h82, 1'b0);
    add_row(8'h53, 1'b0);
    add_row(8'h62, 1'b0);
    add_checked_row(8'h00, bad_cookie);
    // good cookie, type, empty option 0, full server id, request cut in its value
    add_row(8'h63, 1'b0);
    add_row(8'h82, 1'b0);
    add_row(8'h53, 1'b0);
    add_row(8'h63, 1'b0);
    add_row(8'd53, 1'b0);
    add_row(8'h01, 1'b0);
    add_row(8'h07, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'd54, 1'b0);
    add_row(8'h04, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'd50, 1'b0);
    add_row(8'h02, 1'b0);
    add_row(8'hAB, 1'b1);
    foreach (directed_rows[i])
      send_byte(directed_rows[i].data, directed_rows[i].last,
                directed_rows[i].fixed, directed_rows[i].want);

    // random buffers over several register settings
    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) begin
        drain();
        case (phase)
          1: apply_settings(32'h0000_0000, 8'd0, 8'd255, 8'd255, 8'd0, 8'd128);
          2: apply_settings(32'hFFFF_FFFF, 8'd255, 8'd0, 8'd1, 8'd2, 8'd3);
          3: apply_settings($urandom, 8'($urandom_range(7)), 8'($urandom_range(7)),
                            8'($urandom_range(7)), 8'($urandom_range(7)),
                            8'($urandom_range(7)));
          4: apply_settings($urandom, 8'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom), 8'($urandom));
          default: apply_settings(dop_pkg::COOKIE_RST, dop_pkg::END_RST,
                                  dop_pkg::MSGTYPE_RST, dop_pkg::REQUEST_RST,
                                  dop_pkg::LEASE_RST, dop_pkg::SERVER_RST);
        endcase
      end
      calm = (phase == 2);
      target = 24 + (phase + 1) * 238;
      while (items_sent < target) begin
        build_packet();
        foreach (pkt_bytes[i])
          send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, 1'b0, none);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (expected_summaries.size() != 0)
      report_mismatch("results never arrived", 32'(expected_summaries.size()), 32'd0);
    if (mismatch_count == 0) begin
      $display("PASS dhcp_option_parser");
    end else begin
      $display("FAIL dhcp_option_parser");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("FAIL dhcp_option_parser");
    $finish;
  end

endmodule
